// File: design/pptw_pkg.sv
// Shared types, constants and fixed-point helpers of the point projection block.
package pptw_pkg;

   // Word format: signed fixed point, FRAC_W fraction bits
   localparam int WORD_W    = 48;
   localparam int FRAC_W    = 16;
   localparam int HALF_W    = WORD_W / 2;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int ACC_W     = 2 * WORD_W + 2;
   localparam int SAT_W     = ACC_W + 1;
   localparam int WIN_W     = WORD_W + 18;
   localparam int SIZE_W    = 16;
   localparam int IDX_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_LAT   = WORD_W + 1;

   // Item function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_PROJ = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VP_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VP_HEIGHT = 2'd3;

   // Register reset values
   localparam logic [SIZE_W-1:0] VP_WIDTH_RST  = 16'd1920;
   localparam logic [SIZE_W-1:0] VP_HEIGHT_RST = 16'd1080;

   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [ACC_W:0]    ROUND_HALF = 1 << (FRAC_W - 1);
   localparam logic signed [WORD_W:0]   DEPTH_BIAS = (1 << FRAC_W) + 1;

   typedef struct packed {
      logic                     func;
      logic [IDX_W-1:0]         coef_index;
      logic signed [WORD_W-1:0] coef_value;
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic signed [WORD_W-1:0] point_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] window_x;
      logic signed [WORD_W-1:0] window_y;
      logic signed [WORD_W-1:0] window_depth;
      logic                     in_front;
   } rsp_payload_type;

   // Clamp a wide signed value into one word
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v[SAT_W-1:WORD_W-1] == {(SAT_W-WORD_W+1){v[SAT_W-1]}}) begin
         r = v[WORD_W-1:0];
      end else begin
         r = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
      end
      return r;
   endfunction

   // Drop the fraction of a product sum, round half up, then clamp
   function automatic logic signed [WORD_W-1:0] round_acc(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0] t;
      logic signed [SAT_W-1:0] s;
      t = $signed({a[ACC_W-1], a}) + ROUND_HALF;
      s = t >>> FRAC_W;
      return sat_word(s);
   endfunction

endpackage

// File: design/pptw_smul.sv
// Two-stage signed word multiplier built from half-word partial products.
module pptw_smul import pptw_pkg::*; (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [WORD_W-1:0] op_a,
   input  logic signed [WORD_W-1:0] op_b,
   output logic signed [PROD_W-1:0] product
);

   localparam int PP_W = 2 * HALF_W + 2;

   logic signed [HALF_W:0]   a_lo, b_lo;
   logic signed [HALF_W-1:0] a_hi, b_hi;
   logic signed [PP_W-1:0]   ll_in, lh_in, hl_in, hh_in;
   logic signed [PP_W-1:0]   ll_ff, lh_ff, hl_ff, hh_ff;
   logic signed [PROD_W-1:0] product_in, product_ff;

   // Split operands: low halves unsigned, high halves signed
   assign a_lo = $signed({1'b0, op_a[HALF_W-1:0]});
   assign b_lo = $signed({1'b0, op_b[HALF_W-1:0]});
   assign a_hi = op_a[WORD_W-1:HALF_W];
   assign b_hi = op_b[WORD_W-1:HALF_W];

   always_comb begin
      ll_in = a_lo * b_lo;
      lh_in = a_lo * b_hi;
      hl_in = a_hi * b_lo;
      hh_in = a_hi * b_hi;
   end

   // Recombine partial products
   always_comb begin
      product_in = (PROD_W'(hh_ff) <<< (2 * HALF_W))
                 + ((PROD_W'(lh_ff) + PROD_W'(hl_ff)) <<< HALF_W)
                 + PROD_W'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hl_ff      <= hl_in;
         hh_ff      <= hh_in;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// File: design/pptw_sdiv.sv
// Pipelined signed divider: (num * 2^FRAC_W) / den, truncated and clamped to a word.
module pptw_sdiv import pptw_pkg::*; (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [WORD_W-1:0] num,
   input  logic signed [WORD_W-1:0] den,
   output logic signed [WORD_W-1:0] quot
);

   localparam int NUM_W = WORD_W + FRAC_W;
   localparam int QB    = WORD_W - 1;
   localparam int TOP_W = NUM_W - QB;

   logic [WORD_W-1:0] nabs, dabs;
   logic [NUM_W-1:0]  nmag;
   logic              ovf_in;

   logic [WORD_W-1:0] rem_ff [QB+1];
   logic [QB-1:0]     low_ff [QB+1];
   logic [QB-1:0]     q_ff   [QB+1];
   logic [WORD_W-1:0] d_ff   [QB+1];
   logic              neg_ff [QB+1];
   logic              ovf_ff [QB+1];

   logic [WORD_W:0]   trial [QB];
   logic [WORD_W:0]   diff  [QB];

   logic signed [WORD_W-1:0] quot_in, quot_ff;

   // Magnitudes and early overflow check: quotient reaches 2^(WORD_W-1)
   always_comb begin
      nabs   = num[WORD_W-1] ? (~num + 1'b1) : num;
      dabs   = den[WORD_W-1] ? (~den + 1'b1) : den;
      nmag   = {nabs, {FRAC_W{1'b0}}};
      ovf_in = {{(WORD_W-TOP_W){1'b0}}, nmag[NUM_W-1:QB]} >= dabs;
   end

   // One quotient bit per stage
   always_comb begin
      for (int k = 0; k < QB; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][QB-1]};
         diff[k]  = trial[k] - {1'b0, d_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {{(WORD_W-TOP_W){1'b0}}, nmag[NUM_W-1:QB]};
         low_ff[0] <= nmag[QB-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= dabs;
         neg_ff[0] <= num[WORD_W-1] ^ den[WORD_W-1];
         ovf_ff[0] <= ovf_in;
         for (int k = 0; k < QB; k++) begin
            rem_ff[k+1] <= diff[k][WORD_W] ? trial[k][WORD_W-1:0] : diff[k][WORD_W-1:0];
            low_ff[k+1] <= low_ff[k] << 1;
            q_ff[k+1]   <= {q_ff[k][QB-2:0], ~diff[k][WORD_W]};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
         quot_ff <= quot_in;
      end
   end

   // Apply sign, clamp on overflow
   always_comb begin
      if (ovf_ff[QB]) begin
         quot_in = neg_ff[QB] ? WORD_MIN : WORD_MAX;
      end else if (neg_ff[QB]) begin
         quot_in = ~{1'b0, q_ff[QB]} + 1'b1;
      end else begin
         quot_in = {1'b0, q_ff[QB]};
      end
   end

   assign quot = quot_ff;

endmodule

// File: design/point_project_to_window.sv
// Top level of the point projection pipeline: coefficient store, matrix stages, viewport map.
//
//   channel  | ports                          | direction | moves
//   request  | req_valid req_stall req_data   | in        | load or project item
//   response | rsp_valid rsp_stall rsp_data   | out       | window coordinates
//   config   | csr_we csr_index csr_wdata     | in        | viewport registers
//
// One item enters per cycle while no result is stalled; load items leave no result.
// Project results pass stages 0 to 8, the divider, stage 9 and the result register.
// Reset clears the valid bits and the coefficient store and presets the viewport at once.
// A stalled result freezes every stage, and req_stall follows within the same cycle.
module point_project_to_window import pptw_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   logic advance;

   logic [SIZE_W-1:0] vp_x_ff, vp_y_ff, vp_w_ff, vp_h_ff;

   logic signed [WORD_W-1:0] m_ff [16];
   logic signed [WORD_W-1:0] p_ff [16];

   // Stage 0: input register
   logic            s0_valid_ff;
   req_payload_type s0_data_ff;
   logic signed [WORD_W-1:0] pt [3];

   // Stages 1 to 4: eye transform, loads ride along
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_load_ff, s2_load_ff, s3_load_ff, s4_load_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic signed [WORD_W-1:0] s1_coef_ff, s2_coef_ff, s3_coef_ff, s4_coef_ff;
   logic signed [WORD_W-1:0] s1_bias_ff [4];
   logic signed [WORD_W-1:0] s2_bias_ff [4];
   logic signed [PROD_W-1:0] eye_prod [4][3];
   logic signed [ACC_W-1:0]  acc3_in [4];
   logic signed [ACC_W-1:0]  acc3_ff [4];
   logic signed [WORD_W-1:0] eye4_ff [4];

   // Stages 5 to 8: clip transform
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic s5_wz_ff, s6_wz_ff, s7_wz_ff, s8_wz_ff;
   logic signed [WORD_W-1:0] w_in;
   logic signed [WORD_W-1:0] s5_w_ff, s6_w_ff, s7_w_ff, s8_w_ff;
   logic signed [PROD_W-1:0] clip_prod [3][4];
   logic signed [ACC_W-1:0]  acc7_in [3];
   logic signed [ACC_W-1:0]  acc7_ff [3];
   logic signed [WORD_W-1:0] clip8_ff [3];

   // Divider stages
   logic signed [WORD_W-1:0] ndc [3];
   logic dv_ff  [DIV_LAT];
   logic dwz_ff [DIV_LAT];

   // Stage 9 and the result register
   logic s9_valid_ff, s9_wz_ff;
   logic signed [WIN_W-1:0]  wxp_in, wyp_in, s9_wxp_ff, s9_wyp_ff;
   logic signed [WORD_W:0]   dsum;
   logic signed [WORD_W-1:0] s9_depth_ff;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_in, rsp_ff;

   // Viewport mapping: ((prod + size*2^F + 1) >> 1) + origin*2^F, clamped
   function automatic logic signed [WORD_W-1:0] to_window(
      input logic signed [WIN_W-1:0] prod,
      input logic [SIZE_W-1:0]       size,
      input logic [SIZE_W-1:0]       origin
   );
      logic signed [WIN_W-1:0] t, h, s;
      t = prod + $signed(WIN_W'({size, {FRAC_W{1'b0}}})) + WIN_W'(1);
      h = t >>> 1;
      s = h + $signed(WIN_W'({origin, {FRAC_W{1'b0}}}));
      return sat_word(SAT_W'(s));
   endfunction

   // Freeze all stages while a result waits
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Viewport registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff <= '0;
         vp_y_ff <= '0;
         vp_w_ff <= VP_WIDTH_RST;
         vp_h_ff <= VP_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VP_X:      vp_x_ff <= csr_wdata;
            CSR_VP_Y:      vp_y_ff <= csr_wdata;
            CSR_VP_WIDTH:  vp_w_ff <= csr_wdata;
            CSR_VP_HEIGHT: vp_h_ff <= csr_wdata;
         endcase
      end
   end

   // Coefficient store: modelview written where it is read, projection likewise
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            m_ff[i] <= '0;
            p_ff[i] <= '0;
         end
      end else if (advance) begin
         if (s0_valid_ff && s0_data_ff.func == FUNC_LOAD && !s0_data_ff.coef_index[IDX_W-1]) begin
            m_ff[s0_data_ff.coef_index[IDX_W-2:0]] <= s0_data_ff.coef_value;
         end
         if (s4_valid_ff && s4_load_ff && s4_idx_ff[IDX_W-1]) begin
            p_ff[s4_idx_ff[IDX_W-2:0]] <= s4_coef_ff;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) dv_ff[k] <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         // drop load items once the store has them
         s5_valid_ff  <= s4_valid_ff && !s4_load_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         dv_ff[0]     <= s8_valid_ff;
         for (int k = 1; k < DIV_LAT; k++) dv_ff[k] <= dv_ff[k-1];
         s9_valid_ff  <= dv_ff[DIV_LAT-1];
         rsp_valid_ff <= s9_valid_ff;
      end
   end

   // Point operands of the eye transform
   assign pt[0] = s0_data_ff.point_x;
   assign pt[1] = s0_data_ff.point_y;
   assign pt[2] = s0_data_ff.point_z;

   // Eye products: M[r][c] * point[c]
   for (genvar r = 0; r < 4; r++) begin : g_eye_row
      for (genvar c = 0; c < 3; c++) begin : g_eye_col
         pptw_smul u_mul (
            .clock   (clock),
            .enable  (advance),
            .op_a    (m_ff[4*c+r]),
            .op_b    (pt[c]),
            .product (eye_prod[r][c])
         );
      end
   end

   // Clip products: P[r][c] * eye[c]
   for (genvar r = 0; r < 3; r++) begin : g_clip_row
      for (genvar c = 0; c < 4; c++) begin : g_clip_col
         pptw_smul u_mul (
            .clock   (clock),
            .enable  (advance),
            .op_a    (p_ff[4*c+r]),
            .op_b    (eye4_ff[c]),
            .product (clip_prod[r][c])
         );
      end
   end

   // Row sums
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         acc3_in[r] = ACC_W'(eye_prod[r][0]) + ACC_W'(eye_prod[r][1])
                    + ACC_W'(eye_prod[r][2]) + (ACC_W'(s2_bias_ff[r]) <<< FRAC_W);
      end
      for (int r = 0; r < 3; r++) begin
         acc7_in[r] = ACC_W'(clip_prod[r][0]) + ACC_W'(clip_prod[r][1])
                    + ACC_W'(clip_prod[r][2]) + ACC_W'(clip_prod[r][3]);
      end
   end

   // Eye depth negated and clamped
   assign w_in = (eye4_ff[2] == WORD_MIN) ? WORD_MAX : -eye4_ff[2];

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_data_ff <= req_data;

         s1_load_ff <= s0_data_ff.func == FUNC_LOAD;
         s1_idx_ff  <= s0_data_ff.coef_index;
         s1_coef_ff <= s0_data_ff.coef_value;
         for (int r = 0; r < 4; r++) s1_bias_ff[r] <= m_ff[12+r];

         s2_load_ff <= s1_load_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_coef_ff <= s1_coef_ff;
         for (int r = 0; r < 4; r++) s2_bias_ff[r] <= s1_bias_ff[r];

         s3_load_ff <= s2_load_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_coef_ff <= s2_coef_ff;
         for (int r = 0; r < 4; r++) acc3_ff[r] <= acc3_in[r];

         s4_load_ff <= s3_load_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_coef_ff <= s3_coef_ff;
         for (int r = 0; r < 4; r++) eye4_ff[r] <= round_acc(acc3_ff[r]);

         s5_w_ff  <= w_in;
         s5_wz_ff <= eye4_ff[2] == '0;
         s6_w_ff  <= s5_w_ff;
         s6_wz_ff <= s5_wz_ff;
         s7_w_ff  <= s6_w_ff;
         s7_wz_ff <= s6_wz_ff;
         for (int r = 0; r < 3; r++) acc7_ff[r] <= acc7_in[r];
         s8_w_ff  <= s7_w_ff;
         s8_wz_ff <= s7_wz_ff;
         for (int r = 0; r < 3; r++) clip8_ff[r] <= round_acc(acc7_ff[r]);

         dwz_ff[0] <= s8_wz_ff;
         for (int k = 1; k < DIV_LAT; k++) dwz_ff[k] <= dwz_ff[k-1];

         s9_wz_ff    <= dwz_ff[DIV_LAT-1];
         s9_wxp_ff   <= wxp_in;
         s9_wyp_ff   <= wyp_in;
         s9_depth_ff <= dsum[WORD_W:1];

         rsp_ff <= rsp_in;
      end
   end

   // Perspective divide, one divider per clip row
   for (genvar r = 0; r < 3; r++) begin : g_div
      pptw_sdiv u_div (
         .clock  (clock),
         .enable (advance),
         .num    (clip8_ff[r]),
         .den    (s8_w_ff),
         .quot   (ndc[r])
      );
   end

   // Viewport scale products and depth
   always_comb begin
      wxp_in = ndc[0] * $signed({1'b0, vp_w_ff});
      wyp_in = ndc[1] * $signed({1'b0, vp_h_ff});
      dsum   = $signed({ndc[2][WORD_W-1], ndc[2]}) + DEPTH_BIAS;
   end

   // Result: zeros when the eye depth was zero
   always_comb begin
      if (s9_wz_ff) begin
         rsp_in = '0;
      end else begin
         rsp_in.window_x     = to_window(s9_wxp_ff, vp_w_ff, vp_x_ff);
         rsp_in.window_y     = to_window(s9_wyp_ff, vp_h_ff, vp_y_ff);
         rsp_in.window_depth = s9_depth_ff;
         rsp_in.in_front     = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/pptw_checker.sv
// Port-level checks of the point projection block, bound to its top level.
module pptw_checker import pptw_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Input stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // Points at zero eye depth give all-zero coordinates
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_front |->
         rsp_data.window_x == '0 && rsp_data.window_y == '0 && rsp_data.window_depth == '0)
      else $error("zero eye depth gave nonzero coordinates");

endmodule

bind point_project_to_window pptw_checker u_checker (.*);
